FILE: design/circle_arc_tessellator_macros.svh
// assertion macros for the circle arc tessellator
`ifndef CIRCLE_ARC_TESSELLATOR_MACROS_SVH
`define CIRCLE_ARC_TESSELLATOR_MACROS_SVH
`ifndef SYNTHESIS
`define CAT_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define CAT_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define CAT_ASSERT_IMP(label, ante, cons)
`define CAT_ASSERT_NEXT(label, ante, cons)
`endif
`endif

FILE: design/cat_pkg.sv
// types, constants and tables for the circle arc tessellator
`timescale 1ns / 1ps
package cat_pkg;

    localparam logic [5:0] MAX_SEGMENTS = 6'd63;

    localparam logic [1:0] REG_LIN = 2'd0;
    localparam logic [1:0] REG_ANG = 2'd1;

    localparam logic signed [33:0] PI_Q28      = 34'sd843314857;
    localparam logic signed [33:0] TWO_PI_Q28  = 34'sd1686629713;
    localparam logic signed [33:0] HALF_PI_Q28 = 34'sd421657428;
    localparam logic [16:0]        HALF_PI_Q16 = 17'd102944;
    localparam logic signed [33:0] GAIN_Q30    = 34'sd652032874;
    localparam logic [4:0]         CORDIC_STEPS = 5'd28;

    typedef struct packed {
        logic signed [31:0] center_x;
        logic signed [31:0] center_y;
        logic signed [31:0] center_z;
        logic signed [15:0] xaxis_x;
        logic signed [15:0] xaxis_y;
        logic signed [15:0] xaxis_z;
        logic signed [15:0] yaxis_x;
        logic signed [15:0] yaxis_y;
        logic signed [15:0] yaxis_z;
        logic [31:0]        radius;
        logic signed [19:0] start_angle;
        logic signed [19:0] end_angle;
    } arc_t;

    typedef struct packed {
        logic signed [39:0] point_x;
        logic signed [39:0] point_y;
        logic signed [39:0] point_z;
        logic               last;
        logic               clamped;
    } vtx_t;

    function automatic logic signed [33:0] atan_q28(input logic [4:0] idx);
        logic signed [33:0] r;
        unique case (idx)
            5'd0:    r = 34'sd210828714;
            5'd1:    r = 34'sd124459457;
            5'd2:    r = 34'sd65760959;
            5'd3:    r = 34'sd33381290;
            5'd4:    r = 34'sd16755422;
            5'd5:    r = 34'sd8385879;
            5'd6:    r = 34'sd4193963;
            5'd7:    r = 34'sd2097109;
            5'd8:    r = 34'sd1048571;
            5'd9:    r = 34'sd524287;
            5'd10:   r = 34'sd262144;
            5'd11:   r = 34'sd131072;
            5'd12:   r = 34'sd65536;
            5'd13:   r = 34'sd32768;
            5'd14:   r = 34'sd16384;
            5'd15:   r = 34'sd8192;
            5'd16:   r = 34'sd4096;
            5'd17:   r = 34'sd2048;
            5'd18:   r = 34'sd1024;
            5'd19:   r = 34'sd512;
            5'd20:   r = 34'sd256;
            5'd21:   r = 34'sd128;
            5'd22:   r = 34'sd64;
            5'd23:   r = 34'sd32;
            5'd24:   r = 34'sd16;
            5'd25:   r = 34'sd8;
            5'd26:   r = 34'sd4;
            5'd27:   r = 34'sd2;
            default: r = 34'sd0;
        endcase
        return r;
    endfunction

endpackage

FILE: design/circle_arc_tessellator.sv
// circle arc tessellator top level: sequencer, shared divider, cordic and multiplier
//
//  channel | signals                      | beat
//  arc     | arc_valid, arc_ready, arc    | one arc request
//  vtx     | vtx_valid, vtx_ready, vtx    | one vertex, last marks the final one
//  cfg     | cfg_we, cfg_index, cfg_data  | one register write
//
//  setup: when lin < radius, a 30-step division and 17 trial bits for the chord
//  bound, then 21 + 24 divider steps; each vertex then takes a 28-step cordic
//  rotation, three multiplier passes and one output beat.
//  the single serial divider, the cordic rotator and the one multiplier are shared.
//  arc_ready is high only while idle; an empty interval is dropped at acceptance.
//  a stalled vertex holds the sequencer until vtx_ready; rst_n clears all control.
`timescale 1ns / 1ps
`include "circle_arc_tessellator_macros.svh"
module circle_arc_tessellator (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          arc_valid,
    output logic          arc_ready,
    input  cat_pkg::arc_t arc,
    output logic          vtx_valid,
    input  logic          vtx_ready,
    output cat_pkg::vtx_t vtx,
    input  logic          cfg_we,
    input  logic [1:0]    cfg_index,
    input  logic [31:0]   cfg_data
);

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_PREP  = 4'd1;
    localparam logic [3:0] ST_DIVA  = 4'd2;
    localparam logic [3:0] ST_CAND  = 4'd3;
    localparam logic [3:0] ST_WRAP  = 4'd4;
    localparam logic [3:0] ST_FOLD  = 4'd5;
    localparam logic [3:0] ST_ROT   = 4'd6;
    localparam logic [3:0] ST_FIN   = 4'd7;
    localparam logic [3:0] ST_THETA = 4'd8;
    localparam logic [3:0] ST_LOADB = 4'd9;
    localparam logic [3:0] ST_DIVB  = 4'd10;
    localparam logic [3:0] ST_STEP  = 4'd11;
    localparam logic [3:0] ST_DIVC  = 4'd12;
    localparam logic [3:0] ST_VERT  = 4'd13;
    localparam logic [3:0] ST_MUL   = 4'd14;
    localparam logic [3:0] ST_OUT   = 4'd15;

    logic [3:0]         state_reg, state_next;
    cat_pkg::arc_t      arc_reg, arc_next;
    logic [31:0]        lin_reg, lin_next;
    logic [18:0]        ang_reg, ang_next;
    logic [19:0]        span_reg, span_next;
    logic               tight_reg, tight_next;
    logic [30:0]        c_reg, c_next;
    logic [16:0]        a_reg, a_next;
    logic [4:0]         bit_reg, bit_next;
    logic               search_reg, search_next;
    logic               flip_reg, flip_next;
    logic signed [33:0] x_reg, x_next;
    logic signed [33:0] y_reg, y_next;
    logic signed [33:0] z_reg, z_next;
    logic [4:0]         icnt_reg, icnt_next;
    logic signed [33:0] cv_reg, cv_next;
    logic signed [33:0] sv_reg, sv_next;
    logic [31:0]        rem_reg, rem_next;
    logic [29:0]        num_reg, num_next;
    logic [29:0]        quo_reg, quo_next;
    logic [31:0]        div_reg, div_next;
    logic [4:0]         dcnt_reg, dcnt_next;
    logic [18:0]        theta_reg, theta_next;
    logic [5:0]         total_reg, total_next;
    logic               clamp_reg, clamp_next;
    logic [23:0]        step_reg, step_next;
    logic [23:0]        cur_reg, cur_next;
    logic [5:0]         vidx_reg, vidx_next;
    logic [1:0]         axis_reg, axis_next;
    logic [2:0]         ph_reg, ph_next;
    logic signed [51:0] acc_reg, acc_next;
    logic signed [31:0] off_reg, off_next;
    logic [39:0]        prnd_reg, prnd_next;
    logic [39:0]        px_reg, px_next;
    logic [39:0]        py_reg, py_next;
    logic [39:0]        pz_reg, pz_next;
    logic signed [66:0] prod_reg, prod_next;

    // shared divider step
    logic [32:0] rem_sh, rem_sub;
    logic        div_ge;
    logic [29:0] quo_step;

    // cordic step
    logic signed [33:0] xs, ys, x_out;
    logic               cos_ok;

    logic [16:0]        cand;
    logic [18:0]        theta_c;
    logic [20:0]        numer_b;
    logic signed [33:0] mul_a;
    logic signed [32:0] mul_b;
    logic signed [31:0] cen_sel;
    logic signed [15:0] xd_sel, yd_sel;
    logic signed [51:0] acc_rnd;
    logic signed [66:0] prod_rnd;
    logic [39:0]        pt_val;
    logic               is_last;
    logic               arc_empty;

    assign rem_sh   = {rem_reg, num_reg[29]};
    assign div_ge   = rem_sh >= {1'b0, div_reg};
    assign rem_sub  = rem_sh - {1'b0, div_reg};
    assign quo_step = {quo_reg[28:0], div_ge};

    assign xs    = x_reg >>> icnt_reg;
    assign ys    = y_reg >>> icnt_reg;
    assign x_out = flip_reg ? -x_reg : x_reg;
    assign cos_ok = x_out >= $signed({3'b000, c_reg});

    assign cand = a_reg | (17'd1 << bit_reg);

    always_comb
    begin
        theta_c = ang_reg;
        if (tight_reg && ({1'b0, a_reg, 1'b0} < ang_reg))
        begin
            theta_c = {1'b0, a_reg, 1'b0};
        end
        if (theta_c == 19'd0)
        begin
            theta_c = 19'd1;
        end
    end

    assign numer_b = {1'b0, span_reg} + {2'b00, theta_reg} - 21'd1;

    always_comb
    begin
        case (axis_reg)
            2'd0:
            begin
                cen_sel = arc_reg.center_x;
                xd_sel  = arc_reg.xaxis_x;
                yd_sel  = arc_reg.yaxis_x;
            end
            2'd1:
            begin
                cen_sel = arc_reg.center_y;
                xd_sel  = arc_reg.xaxis_y;
                yd_sel  = arc_reg.yaxis_y;
            end
            default:
            begin
                cen_sel = arc_reg.center_z;
                xd_sel  = arc_reg.xaxis_z;
                yd_sel  = arc_reg.yaxis_z;
            end
        endcase
    end

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        if (state_reg == ST_MUL)
        begin
            case (ph_reg)
                3'd0:
                begin
                    mul_a = cv_reg;
                    mul_b = {{17{xd_sel[15]}}, xd_sel};
                end
                3'd1:
                begin
                    mul_a = sv_reg;
                    mul_b = {{17{yd_sel[15]}}, yd_sel};
                end
                3'd4:
                begin
                    mul_a = {{2{off_reg[31]}}, off_reg};
                    mul_b = {1'b0, arc_reg.radius};
                end
                default:
                begin
                    mul_a = '0;
                    mul_b = '0;
                end
            endcase
        end
    end

    assign prod_next = mul_a * mul_b;
    assign acc_rnd   = acc_reg + 52'sd524288;
    assign prod_rnd  = prod_reg + 67'sd8388608;
    assign pt_val    = {{8{cen_sel[31]}}, cen_sel} + prnd_reg;
    assign is_last   = vidx_reg == total_reg;
    assign arc_empty = arc.start_angle >= arc.end_angle;

    always_comb
    begin
        state_next  = state_reg;
        arc_next    = arc_reg;
        lin_next    = lin_reg;
        ang_next    = ang_reg;
        span_next   = span_reg;
        tight_next  = tight_reg;
        c_next      = c_reg;
        a_next      = a_reg;
        bit_next    = bit_reg;
        search_next = search_reg;
        flip_next   = flip_reg;
        x_next      = x_reg;
        y_next      = y_reg;
        z_next      = z_reg;
        icnt_next   = icnt_reg;
        cv_next     = cv_reg;
        sv_next     = sv_reg;
        rem_next    = rem_reg;
        num_next    = num_reg;
        quo_next    = quo_reg;
        div_next    = div_reg;
        dcnt_next   = dcnt_reg;
        theta_next  = theta_reg;
        total_next  = total_reg;
        clamp_next  = clamp_reg;
        step_next   = step_reg;
        cur_next    = cur_reg;
        vidx_next   = vidx_reg;
        axis_next   = axis_reg;
        ph_next     = ph_reg;
        acc_next    = acc_reg;
        off_next    = off_reg;
        prnd_next   = prnd_reg;
        px_next     = px_reg;
        py_next     = py_reg;
        pz_next     = pz_reg;

        if (cfg_we)
        begin
            unique case (cfg_index)
                cat_pkg::REG_LIN: lin_next = cfg_data;
                cat_pkg::REG_ANG: ang_next = cfg_data[18:0];
                default:          lin_next = lin_reg;
            endcase
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (arc_valid && !arc_empty)
                begin
                    arc_next   = arc;
                    state_next = ST_PREP;
                end
            end
            ST_PREP:
            begin
                span_next   = 20'(arc_reg.end_angle - arc_reg.start_angle);
                tight_next  = lin_reg < arc_reg.radius;
                search_next = 1'b1;
                a_next      = '0;
                bit_next    = 5'd16;
                rem_next    = lin_reg;
                num_next    = '0;
                quo_next    = '0;
                div_next    = arc_reg.radius;
                dcnt_next   = 5'd30;
                state_next  = (lin_reg < arc_reg.radius) ? ST_DIVA : ST_THETA;
            end
            ST_DIVA, ST_DIVB, ST_DIVC:
            begin
                rem_next  = div_ge ? rem_sub[31:0] : rem_sh[31:0];
                num_next  = {num_reg[28:0], 1'b0};
                quo_next  = quo_step;
                dcnt_next = dcnt_reg - 5'd1;
                if (dcnt_reg == 5'd1)
                begin
                    if (state_reg == ST_DIVA)
                    begin
                        c_next     = 31'h4000_0000 - {1'b0, quo_step};
                        state_next = ST_CAND;
                    end
                    else if (state_reg == ST_DIVB)
                    begin
                        if (quo_step[20:0] > {15'd0, cat_pkg::MAX_SEGMENTS})
                        begin
                            total_next = cat_pkg::MAX_SEGMENTS;
                            clamp_next = 1'b1;
                        end
                        else
                        begin
                            total_next = quo_step[5:0];
                            clamp_next = 1'b0;
                        end
                        state_next = ST_STEP;
                    end
                    else
                    begin
                        step_next   = quo_step[23:0];
                        cur_next    = {arc_reg.start_angle, 4'b0000};
                        vidx_next   = '0;
                        search_next = 1'b0;
                        state_next  = ST_VERT;
                    end
                end
            end
            ST_CAND:
            begin
                if (cand <= cat_pkg::HALF_PI_Q16)
                begin
                    z_next     = {5'd0, cand, 12'd0};
                    x_next     = cat_pkg::GAIN_Q30;
                    y_next     = '0;
                    flip_next  = 1'b0;
                    state_next = ST_WRAP;
                end
                else if (bit_reg == 5'd0)
                begin
                    state_next = ST_THETA;
                end
                else
                begin
                    bit_next = bit_reg - 5'd1;
                end
            end
            ST_WRAP:
            begin
                if (z_reg > cat_pkg::PI_Q28)
                begin
                    z_next = z_reg - cat_pkg::TWO_PI_Q28;
                end
                else if (z_reg < -cat_pkg::PI_Q28)
                begin
                    z_next = z_reg + cat_pkg::TWO_PI_Q28;
                end
                state_next = ST_FOLD;
            end
            ST_FOLD:
            begin
                if (z_reg > cat_pkg::HALF_PI_Q28)
                begin
                    z_next    = z_reg - cat_pkg::PI_Q28;
                    flip_next = 1'b1;
                end
                else if (z_reg < -cat_pkg::HALF_PI_Q28)
                begin
                    z_next    = z_reg + cat_pkg::PI_Q28;
                    flip_next = 1'b1;
                end
                icnt_next  = '0;
                state_next = ST_ROT;
            end
            ST_ROT:
            begin
                if (!z_reg[33])
                begin
                    x_next = x_reg - ys;
                    y_next = y_reg + xs;
                    z_next = z_reg - cat_pkg::atan_q28(icnt_reg);
                end
                else
                begin
                    x_next = x_reg + ys;
                    y_next = y_reg - xs;
                    z_next = z_reg + cat_pkg::atan_q28(icnt_reg);
                end
                icnt_next = icnt_reg + 5'd1;
                if (icnt_reg == cat_pkg::CORDIC_STEPS - 5'd1)
                begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN:
            begin
                if (search_reg)
                begin
                    if (cos_ok)
                    begin
                        a_next = cand;
                    end
                    if (bit_reg == 5'd0)
                    begin
                        state_next = ST_THETA;
                    end
                    else
                    begin
                        bit_next   = bit_reg - 5'd1;
                        state_next = ST_CAND;
                    end
                end
                else
                begin
                    cv_next    = x_out;
                    sv_next    = flip_reg ? -y_reg : y_reg;
                    axis_next  = '0;
                    ph_next    = '0;
                    state_next = ST_MUL;
                end
            end
            ST_THETA:
            begin
                theta_next = theta_c;
                state_next = ST_LOADB;
            end
            ST_LOADB:
            begin
                num_next   = {numer_b, 9'd0};
                rem_next   = '0;
                quo_next   = '0;
                div_next   = {13'd0, theta_reg};
                dcnt_next  = 5'd21;
                state_next = ST_DIVB;
            end
            ST_STEP:
            begin
                num_next   = {span_reg, 10'd0};
                rem_next   = '0;
                quo_next   = '0;
                div_next   = {26'd0, total_reg};
                dcnt_next  = 5'd24;
                state_next = ST_DIVC;
            end
            ST_VERT:
            begin
                z_next     = {{2{cur_reg[23]}}, cur_reg, 8'd0};
                x_next     = cat_pkg::GAIN_Q30;
                y_next     = '0;
                flip_next  = 1'b0;
                state_next = ST_WRAP;
            end
            ST_MUL:
            begin
                ph_next = ph_reg + 3'd1;
                case (ph_reg)
                    3'd1: acc_next  = prod_reg[51:0];
                    3'd2: acc_next  = acc_reg + prod_reg[51:0];
                    3'd3: off_next  = acc_rnd[51:20];
                    3'd5: prnd_next = prod_rnd[63:24];
                    3'd6:
                    begin
                        ph_next = '0;
                        case (axis_reg)
                            2'd0:    px_next = pt_val;
                            2'd1:    py_next = pt_val;
                            default: pz_next = pt_val;
                        endcase
                        if (axis_reg == 2'd2)
                        begin
                            state_next = ST_OUT;
                        end
                        else
                        begin
                            axis_next = axis_reg + 2'd1;
                        end
                    end
                    default: acc_next = acc_reg;
                endcase
            end
            ST_OUT:
            begin
                if (vtx_ready)
                begin
                    if (is_last)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        cur_next   = cur_reg + step_reg;
                        vidx_next  = vidx_reg + 6'd1;
                        state_next = ST_VERT;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            lin_reg    <= 32'd655;
            ang_reg    <= 19'd6554;
            search_reg <= 1'b0;
            dcnt_reg   <= '0;
            icnt_reg   <= '0;
            bit_reg    <= '0;
            axis_reg   <= '0;
            ph_reg     <= '0;
            total_reg  <= '0;
            step_reg   <= '0;
            cur_reg    <= '0;
            vidx_reg   <= '0;
            clamp_reg  <= 1'b0;
            tight_reg  <= 1'b0;
            flip_reg   <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            lin_reg    <= lin_next;
            ang_reg    <= ang_next;
            search_reg <= search_next;
            dcnt_reg   <= dcnt_next;
            icnt_reg   <= icnt_next;
            bit_reg    <= bit_next;
            axis_reg   <= axis_next;
            ph_reg     <= ph_next;
            total_reg  <= total_next;
            step_reg   <= step_next;
            cur_reg    <= cur_next;
            vidx_reg   <= vidx_next;
            clamp_reg  <= clamp_next;
            tight_reg  <= tight_next;
            flip_reg   <= flip_next;
        end
    end

    // datapath, no reset
    always_ff @(posedge clk)
    begin
        arc_reg   <= arc_next;
        span_reg  <= span_next;
        c_reg     <= c_next;
        a_reg     <= a_next;
        x_reg     <= x_next;
        y_reg     <= y_next;
        z_reg     <= z_next;
        cv_reg    <= cv_next;
        sv_reg    <= sv_next;
        rem_reg   <= rem_next;
        num_reg   <= num_next;
        quo_reg   <= quo_next;
        div_reg   <= div_next;
        theta_reg <= theta_next;
        acc_reg   <= acc_next;
        off_reg   <= off_next;
        prnd_reg  <= prnd_next;
        px_reg    <= px_next;
        py_reg    <= py_next;
        pz_reg    <= pz_next;
        prod_reg  <= prod_next;
    end

    assign arc_ready   = state_reg == ST_IDLE;
    assign vtx_valid   = state_reg == ST_OUT;
    assign vtx.point_x = px_reg;
    assign vtx.point_y = py_reg;
    assign vtx.point_z = pz_reg;
    assign vtx.last    = is_last;
    assign vtx.clamped = clamp_reg;

    `CAT_ASSERT_IMP(a_one_side, vtx_valid, !arc_ready)
    `CAT_ASSERT_NEXT(a_last_idle, vtx_valid && vtx_ready && vtx.last, arc_ready)
    `CAT_ASSERT_IMP(a_vidx_bound, vtx_valid, vidx_reg <= total_reg)
    `CAT_ASSERT_IMP(a_rot_bound, state_reg == ST_ROT, icnt_reg < cat_pkg::CORDIC_STEPS)

endmodule

FILE: test/tb_circle_arc_tessellator.sv
// testbench for the circle arc tessellator: directed table, then random arcs against a predictor
`timescale 1ns / 1ps
module tb_circle_arc_tessellator;

    localparam int LIMIT = 12000000;

    typedef struct {
        cat_pkg::arc_t arc;
        int            n_typed;
        logic          clamp_typed;
    } arc_row_t;

    logic          clk;
    logic          rst_n;
    logic          arc_valid;
    logic          arc_ready;
    cat_pkg::arc_t arc;
    logic          vtx_valid;
    logic          vtx_ready;
    cat_pkg::vtx_t vtx;
    logic          cfg_we;
    logic [1:0]    cfg_index;
    logic [31:0]   cfg_data;

    cat_pkg::vtx_t expected_vertices[$];
    longint  lin_defl;
    longint  ang_defl;
    int      errors;
    int      cycles;
    bit      quiet;
    bit      long_hold_req;
    int      hold_left;

    longint  atan_q28_tab[28] = '{
        210828714, 124459457, 65760959, 33381290, 16755422,
        8385879, 4193963, 2097109, 1048571, 524287,
        262144, 131072, 65536, 32768, 16384, 8192, 4096,
        2048, 1024, 512, 256, 128, 64, 32, 16, 8, 4, 2
    };

    circle_arc_tessellator i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .arc_valid (arc_valid),
        .arc_ready (arc_ready),
        .arc       (arc),
        .vtx_valid (vtx_valid),
        .vtx_ready (vtx_ready),
        .vtx       (vtx),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        clk = 1'b1;
        #4;
        clk = 1'b0;
        #4;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // q4.28 angle in, q2.30 cosine and sine out
    function automatic void rotate_cordic(input longint angle, output longint cv,
                                          output longint sv);
        longint z;
        longint x;
        longint y;
        longint dx;
        longint dy;
        bit     flip;
        z = angle;
        x = cat_pkg::GAIN_Q30;
        y = 0;
        flip = 0;
        while (z > longint'(cat_pkg::PI_Q28))
            z -= cat_pkg::TWO_PI_Q28;
        while (z < -longint'(cat_pkg::PI_Q28))
            z += cat_pkg::TWO_PI_Q28;
        if (z > longint'(cat_pkg::HALF_PI_Q28))
        begin
            z -= cat_pkg::PI_Q28;
            flip = 1;
        end
        else if (z < -longint'(cat_pkg::HALF_PI_Q28))
        begin
            z += cat_pkg::PI_Q28;
            flip = 1;
        end
        for (int i = 0; i < 28; i++)
        begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0)
            begin
                x -= dx;
                y += dy;
                z -= atan_q28_tab[i];
            end
            else
            begin
                x += dx;
                y -= dy;
                z += atan_q28_tab[i];
            end
        end
        cv = flip ? -x : x;
        sv = flip ? -y : y;
    endfunction

    task automatic predict_vertices(input cat_pkg::arc_t a);
        longint t0;
        longint t1;
        longint span;
        longint r;
        longint theta;
        longint chord_cos;
        longint half;
        longint cand;
        longint cv;
        longint sv;
        longint count;
        longint step;
        longint angle;
        longint cen[3];
        longint xd[3];
        longint yd[3];
        longint pt[3];
        longint off;
        longint p;
        bit     clamp;
        cat_pkg::vtx_t v;
        t0 = longint'(a.start_angle);
        t1 = longint'(a.end_angle);
        if (t0 >= t1)
            return;
        cen = '{longint'(a.center_x), longint'(a.center_y), longint'(a.center_z)};
        xd = '{longint'(a.xaxis_x), longint'(a.xaxis_y), longint'(a.xaxis_z)};
        yd = '{longint'(a.yaxis_x), longint'(a.yaxis_y), longint'(a.yaxis_z)};
        r = longint'({32'd0, a.radius});
        span = t1 - t0;
        theta = ang_defl;
        if (lin_defl < r)
        begin
            chord_cos = (longint'(1) << 30) - ((lin_defl << 30) / r);
            half = 0;
            for (int b = 16; b >= 0; b--)
            begin
                cand = half | (longint'(1) << b);
                if (cand <= longint'(cat_pkg::HALF_PI_Q16))
                begin
                    rotate_cordic(cand * 4096, cv, sv);
                    if (cv >= chord_cos)
                        half = cand;
                end
            end
            if (2 * half < theta)
                theta = 2 * half;
        end
        if (theta < 1)
            theta = 1;
        count = (span + theta - 1) / theta;
        clamp = 0;
        if (count > 63)
        begin
            count = 63;
            clamp = 1;
        end
        step = ((span * 16) / count) & 64'hFFFFFF;
        angle = t0 * 16;
        for (longint k = 0; k <= count; k++)
        begin
            rotate_cordic(angle * 256, cv, sv);
            for (int i = 0; i < 3; i++)
            begin
                off = (cv * xd[i] + sv * yd[i] + (longint'(1) << 19)) >>> 20;
                p = (off * r + (longint'(1) << 23)) >>> 24;
                pt[i] = cen[i] + p;
            end
            v.point_x = pt[0][39:0];
            v.point_y = pt[1][39:0];
            v.point_z = pt[2][39:0];
            v.last = (k == count);
            v.clamped = clamp;
            expected_vertices.push_back(v);
            if (k < count)
                angle += step;
        end
    endtask

    task automatic report_mismatch(input string field, input longint got, input longint want);
        $display("mismatch %s: got %0h want %0h", field, got, want);
        errors++;
    endtask

    always @(posedge clk)
    begin
        cat_pkg::vtx_t w;
        if (rst_n && vtx_valid && vtx_ready)
        begin
            if (expected_vertices.size() == 0)
                report_mismatch("unexpected beat", 0, 0);
            else
            begin
                w = expected_vertices.pop_front();
                if (vtx.point_x !== w.point_x)
                    report_mismatch("point_x", vtx.point_x, w.point_x);
                if (vtx.point_y !== w.point_y)
                    report_mismatch("point_y", vtx.point_y, w.point_y);
                if (vtx.point_z !== w.point_z)
                    report_mismatch("point_z", vtx.point_z, w.point_z);
                if (vtx.last !== w.last)
                    report_mismatch("last", vtx.last, w.last);
                if (vtx.clamped !== w.clamped)
                    report_mismatch("clamped", vtx.clamped, w.clamped);
            end
        end
    end

    // receiver stalls, including the long hold-off
    always @(posedge clk)
    begin
        if (long_hold_req)
        begin
            long_hold_req <= 1'b0;
            hold_left <= 3000;
            vtx_ready <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            vtx_ready <= 1'b0;
        end
        else if (!quiet && $urandom_range(0, 7) == 0)
        begin
            hold_left <= $urandom_range(0, 16);
            vtx_ready <= 1'b0;
        end
        else
            vtx_ready <= 1'b1;
    end

    function automatic cat_pkg::arc_t make_arc(input int cx, input int cy, input int cz,
                                               input int xx, input int xy, input int xz,
                                               input int yx, input int yy, input int yz,
                                               input logic [31:0] r, input int s,
                                               input int e);
        cat_pkg::arc_t a;
        a.center_x = cx;
        a.center_y = cy;
        a.center_z = cz;
        a.xaxis_x = 16'(xx);
        a.xaxis_y = 16'(xy);
        a.xaxis_z = 16'(xz);
        a.yaxis_x = 16'(yx);
        a.yaxis_y = 16'(yy);
        a.yaxis_z = 16'(yz);
        a.radius = r;
        a.start_angle = 20'(s);
        a.end_angle = 20'(e);
        return a;
    endfunction

    task automatic offer_arc(input cat_pkg::arc_t a);
        if (!quiet && $urandom_range(0, 3) == 0)
        begin
            arc_valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge clk);
        end
        arc_valid <= 1'b1;
        arc <= a;
        do
            @(posedge clk);
        while (!arc_ready);
    endtask

    task automatic wait_idle();
        arc_valid <= 1'b0;
        @(posedge clk);
        while (expected_vertices.size() != 0 || !arc_ready)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    // the caller drops cfg_we after its last write
    task automatic write_reg(input logic [1:0] idx, input logic [31:0] data);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
        if (idx == cat_pkg::REG_LIN)
            lin_defl = longint'({32'd0, data});
        else if (idx == cat_pkg::REG_ANG)
            ang_defl = longint'({45'd0, data[18:0]});
    endtask

    function automatic cat_pkg::arc_t random_arc();
        cat_pkg::arc_t a;
        int   span;
        int   s;
        int   lim;
        a.center_x = $urandom;
        a.center_y = $urandom;
        a.center_z = $urandom;
        a.xaxis_x = 16'($urandom);
        a.xaxis_y = 16'($urandom);
        a.xaxis_z = 16'($urandom);
        a.yaxis_x = 16'($urandom);
        a.yaxis_y = 16'($urandom);
        a.yaxis_z = 16'($urandom);
        a.radius = $urandom;
        a.start_angle = 20'($urandom);
        a.end_angle = 20'($urandom);
        if ($urandom_range(0, 9) != 0)
        begin
            a.xaxis_x = 16'($urandom_range(0, 32768) - 16384);
            a.xaxis_y = 16'($urandom_range(0, 32768) - 16384);
            a.xaxis_z = 16'($urandom_range(0, 32768) - 16384);
            a.yaxis_x = 16'($urandom_range(0, 32768) - 16384);
            a.yaxis_y = 16'($urandom_range(0, 32768) - 16384);
            a.yaxis_z = 16'($urandom_range(0, 32768) - 16384);
        end
        case ($urandom_range(0, 3))
            0: a.radius = $urandom_range(1, 1 << 20);
            1: a.radius = $urandom_range(1, 1 << 26);
            default: a.radius = $urandom;
        endcase
        if ($urandom_range(0, 9) != 0)
        begin
            lim = (ang_defl > 1) ? int'(ang_defl) * 8 : 8;
            if (lim > 1048575)
                lim = 1048575;
            span = $urandom_range(1, lim);
            s = int'($urandom_range(0, 1048575 - span)) - 524288;
            a.start_angle = 20'(s);
            a.end_angle = 20'(s + span);
        end
        return a;
    endfunction

    arc_row_t      rows[$];
    arc_row_t      row;
    cat_pkg::vtx_t tv;

    initial
    begin
        rst_n = 1'b0;
        arc_valid = 1'b0;
        arc = '0;
        vtx_ready = 1'b0;
        cfg_we = 1'b0;
        cfg_index = cat_pkg::REG_LIN;
        cfg_data = '0;
        errors = 0;
        cycles = 0;
        quiet = 0;
        long_hold_req = 0;
        hold_left = 0;
        lin_defl = 655;
        ang_defl = 6554;

        // typed rows: empty intervals and zero directions, which sit on the center
        rows.push_back('{make_arc(5, 6, 7, 16384, 0, 0, 0, 16384, 0, 65536, 100, 100), 0, 0});
        rows.push_back('{make_arc(5, 6, 7, 16384, 0, 0, 0, 16384, 0, 65536, 524287, -524288),
                         0, 0});
        rows.push_back('{make_arc(-2147483648, 2147483647, 0, 0, 0, 0, 0, 0, 0, 1, 0, 1),
                         2, 0});
        rows.push_back('{make_arc(123, -456, 789, 0, 0, 0, 0, 0, 0, 1, -524288, 524287),
                         64, 1});
        // predicted rows
        rows.push_back('{make_arc(0, 0, 0, 16384, 0, 0, 0, 16384, 0, 65536, 0, 102944), -1, 0});
        rows.push_back('{make_arc(2147483647, 2147483647, 2147483647, 16384, 16384, 16384,
                                  16384, 16384, 16384, 32'hFFFFFFFF, 0, 40000), -1, 0});
        rows.push_back('{make_arc(-2147483648, -2147483648, -2147483648, -16384, -16384,
                                  -16384, -16384, -16384, -16384, 32'hFFFFFFFF,
                                  -524288, -500000), -1, 0});
        rows.push_back('{make_arc(0, 0, 0, 16384, 0, 0, 0, 16384, 0, 1, -205887, 205887),
                         -1, 0});
        rows.push_back('{make_arc(1000, 2000, 3000, 0, 16384, 0, 0, 0, 16384, 655, 300000,
                                  524287), -1, 0});
        rows.push_back('{make_arc(0, 0, 0, 16384, 0, 0, 0, 16384, 0, 656, 0, 20000), -1, 0});
        rows.push_back('{make_arc(0, 0, 0, 16384, 0, 0, 0, 16384, 0, 0, 0, 30000), -1, 0});
        rows.push_back('{make_arc(0, 0, 0, 32767, -32768, 32767, -32768, 32767, -32768,
                                  32'hFFFFFFFF, -10000, 10000), -1, 0});
        rows.push_back('{make_arc(0, 0, 0, 16384, 0, 0, 0, 16384, 0, 32'h7FFFFFFF, 0, 1),
                         -1, 0});
        rows.push_back('{make_arc(7, 7, 7, 11585, 11585, 0, -11585, 11585, 0, 65536000, 0,
                                  411775), -1, 0});

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (rows[i])
        begin
            row = rows[i];
            offer_arc(row.arc);
            if (row.n_typed < 0)
                predict_vertices(row.arc);
            else
                for (int k = 0; k < row.n_typed; k++)
                begin
                    tv.point_x = {{8{row.arc.center_x[31]}}, row.arc.center_x};
                    tv.point_y = {{8{row.arc.center_y[31]}}, row.arc.center_y};
                    tv.point_z = {{8{row.arc.center_z[31]}}, row.arc.center_z};
                    tv.last = (k == row.n_typed - 1);
                    tv.clamped = row.clamp_typed;
                    expected_vertices.push_back(tv);
                end
        end

        for (int phase = 0; phase < 6; phase++)
        begin
            wait_idle();
            case (phase)
                0:
                begin
                    write_reg(cat_pkg::REG_LIN, 32'd0);
                    write_reg(cat_pkg::REG_ANG, 32'hFFF80000 | 32'd411775);
                end
                1:
                begin
                    write_reg(cat_pkg::REG_LIN, 32'hFFFFFFFF);
                    write_reg(cat_pkg::REG_ANG, 32'd0);
                end
                2:
                begin
                    write_reg(cat_pkg::REG_LIN, $urandom_range(1, 1 << 16));
                    write_reg(cat_pkg::REG_ANG, $urandom_range(1000, 60000));
                    write_reg(2'd2, $urandom);
                    write_reg(2'd3, $urandom);
                end
                3:
                begin
                    write_reg(cat_pkg::REG_LIN, $urandom);
                    write_reg(cat_pkg::REG_ANG, 32'h7FFFF);
                end
                4:
                begin
                    write_reg(cat_pkg::REG_LIN, $urandom_range(0, 4000));
                    write_reg(cat_pkg::REG_ANG, $urandom_range(1, 411775));
                end
                default:
                begin
                    write_reg(cat_pkg::REG_LIN, 32'd655);
                    write_reg(cat_pkg::REG_ANG, 32'd6554);
                    quiet = 1;
                end
            endcase
            cfg_we <= 1'b0;
            for (int n = 0; n < 65; n++)
            begin
                if (phase == 1 && n == 10)
                    long_hold_req = 1;
                if (phase == 2 && n == 30)
                begin
                    arc_valid <= 1'b0;
                    @(posedge clk);
                    while (expected_vertices.size() != 0)
                        @(posedge clk);
                end
                row.arc = random_arc();
                offer_arc(row.arc);
                predict_vertices(row.arc);
            end
        end

        arc_valid <= 1'b0;
        while (expected_vertices.size() != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
        if (errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
